@@ sv/box_downscale_2x2_macros.svh @@
`ifndef BOX_DOWNSCALE_2X2_MACROS_SVH
`define BOX_DOWNSCALE_2X2_MACROS_SVH

// same-cycle implication, sampled on clk, off during reset
`define BXDS_ASSERT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define BXDS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ sv/bxds_pkg.sv @@
`default_nettype none

package bxds_pkg;

	localparam int PIX_W = 8;
	localparam int SUM_W = PIX_W + 1;
	localparam int NCH   = 3;
	localparam int CFG_W = 10;
	localparam int POS_W = 8;

	typedef logic [NCH-1:0][PIX_W-1:0] pix_t;
	typedef logic [NCH-1:0][SUM_W-1:0] sum_t;

	typedef enum logic [0:0] {
		REG_TILE_WIDTH = 1'b0,
		REG_COLOR_MODE = 1'b1
	} reg_idx_t;

	localparam logic [CFG_W-1:0] TILE_WIDTH_RST = 10'd256;
	localparam logic             COLOR_MODE_RST = 1'b1;

	// position of the pixel being taken
	typedef struct packed {
		logic             active;   // inside the even-sized part of the tile
		logic             odd_col;
		logic             odd_row;
		logic             done;     // last block of the tile
		logic [POS_W-1:0] col_h;
		logic [POS_W-1:0] row_h;
	} pos_t;

endpackage

`default_nettype wire

@@ sv/bxds_line.sv @@
`default_nettype none

module bxds_line #(
	parameter int DEPTH = 256,
	parameter int AW    = 8
) (
	input  wire logic              clk,
	input  wire logic              wr_en,
	input  wire logic [AW-1:0]     wr_addr,
	input  wire bxds_pkg::sum_t    wr_data,
	input  wire logic              rd_en,
	input  wire logic [AW-1:0]     rd_addr,
	output bxds_pkg::sum_t         rd_data
);
	import bxds_pkg::*;

	sum_t mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

`default_nettype wire

@@ sv/bxds_pos.sv @@
`default_nettype none

module bxds_pos #(
	parameter int MAX_TILE_WIDTH = 512,
	parameter int CW             = 9,
	parameter int WW             = 10,
	parameter int LW             = 8
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         advance,
	input  wire logic [bxds_pkg::CFG_W-1:0]   tile_width,
	output bxds_pkg::pos_t                    pos,
	output logic [LW-1:0]                     line_idx
);
	import bxds_pkg::*;

	logic [CW-1:0] col_q;
	logic [CW-1:0] row_q;
	logic [WW-1:0] tw_x;
	logic [WW-1:0] w;
	logic [WW-1:0] h;
	logic [WW-1:0] col_h;
	logic [WW-1:0] row_h;
	logic [WW-1:0] col_nx;
	logic [WW-1:0] row_nx;

	always_comb begin
		tw_x = WW'(tile_width);
		// clamp to the supported range
		if (tw_x < WW'(2)) begin
			w = WW'(2);
		end else if (tw_x > WW'(MAX_TILE_WIDTH)) begin
			w = WW'(MAX_TILE_WIDTH);
		end else begin
			w = tw_x;
		end
		h      = w >> 1;
		col_h  = WW'(col_q) >> 1;
		row_h  = WW'(row_q) >> 1;
		col_nx = WW'(col_q) + WW'(1);
		row_nx = WW'(row_q) + WW'(1);

		pos.active  = (col_h < h) && (row_h < h);
		pos.odd_col = col_q[0];
		pos.odd_row = row_q[0];
		pos.done    = (col_h == h - WW'(1)) && (row_h == h - WW'(1));
		pos.col_h   = POS_W'(col_h);
		pos.row_h   = POS_W'(row_h);
		line_idx    = LW'(col_h);
	end

	// a lowered width mid-tile can leave the position past the end: wrap
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (advance) begin
			if (col_nx >= w) begin
				col_q <= '0;
				row_q <= (row_nx >= w) ? '0 : CW'(row_nx);
			end else begin
				col_q <= CW'(col_nx);
			end
		end
	end

endmodule

`default_nettype wire

@@ sv/bxds_out.sv @@
`default_nettype none

module bxds_out (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         load,
	input  wire bxds_pkg::sum_t               line_sum,
	input  wire bxds_pkg::sum_t               pair_sum,
	input  wire logic [bxds_pkg::POS_W-1:0]   col_h,
	input  wire logic [bxds_pkg::POS_W-1:0]   row_h,
	input  wire logic                         done,
	output logic                              can_load,
	output logic                              m_tvalid,
	input  wire logic                         m_tready,
	output logic [39:0]                       m_tdata,  // avg_c0, avg_c1, avg_c2, out_col, out_row
	output logic                              m_tlast   // tile_done
);
	import bxds_pkg::*;

	logic [SUM_W:0] quad [NCH];
	pix_t           avg;

	always_comb begin
		for (int c = 0; c < NCH; c++) begin
			quad[c] = (SUM_W+1)'(line_sum[c]) + (SUM_W+1)'(pair_sum[c]);
			avg[c]  = quad[c][SUM_W:2];
		end
	end

	assign can_load = !m_tvalid || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (can_load) begin
			m_tvalid <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (load && can_load) begin
			m_tdata <= {row_h, col_h, avg[2], avg[1], avg[0]};
			m_tlast <= done;
		end
	end

endmodule

`default_nettype wire

@@ sv/box_downscale_2x2.sv @@
// 2x2 box downscaler. Takes a square tile of tile_width x tile_width pixels in
// raster order, one pixel per clock, and emits one pixel per 2x2 block with each
// channel the truncated mean of the four inputs. A result is completed by the
// second pixel of each pair on odd rows. It is registered in the s1 stage, then
// loaded into the output register, which raises m_tvalid and holds it under
// back-pressure. The last result of a tile has tlast set. With an odd width the
// last column and row are dropped. Without back-pressure the sustained rate is
// one pixel per clock. The line store of pair sums (MAX_TILE_WIDTH/2 entries)
// has its own write port and a registered read port, so it never stalls the
// input. The input stalls only while a completed result waits behind a held
// output under back-pressure. The line store needs no clearing after reset.
// Change registers only between tiles, with no request in flight.
`default_nettype none

module box_downscale_2x2 #(
	parameter int MAX_TILE_WIDTH = 512,
	parameter int CHANNELS       = 3
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         s_tvalid,
	output logic                              s_tready,
	input  wire logic [23:0]                  s_tdata,  // pix_c0, pix_c1, pix_c2
	output logic                              m_tvalid,
	input  wire logic                         m_tready,
	output logic [39:0]                       m_tdata,  // avg_c0, avg_c1, avg_c2, out_col, out_row
	output logic                              m_tlast,  // tile_done
	input  wire logic                         cfg_valid,
	output logic                              cfg_ready,
	input  wire logic                         cfg_index,
	input  wire logic [bxds_pkg::CFG_W-1:0]   cfg_data
);
	import bxds_pkg::*;

	`include "box_downscale_2x2_macros.svh"

	localparam int CW    = $clog2(MAX_TILE_WIDTH);
	localparam int WW    = (CW + 1 > CFG_W) ? CW + 1 : CFG_W;
	localparam int DEPTH = (MAX_TILE_WIDTH > 2) ? MAX_TILE_WIDTH / 2 : 1;
	localparam int LW    = (MAX_TILE_WIDTH > 2) ? $clog2(MAX_TILE_WIDTH / 2) : 1;

	logic [CFG_W-1:0] tile_width_q;
	logic             color_mode_q;

	pos_t          pos;
	logic [LW-1:0] line_idx;
	logic          in_acc;
	logic          blk_end;
	logic          out_ready;
	pix_t          px;
	pix_t          held_q;
	sum_t          pair;
	sum_t          line_rd;

	logic          s1_valid;
	logic          s1_emit;
	logic          s1_done;
	logic [POS_W-1:0] s1_col;
	logic [POS_W-1:0] s1_row;
	sum_t          s1_pair;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tile_width_q <= TILE_WIDTH_RST;
			color_mode_q <= COLOR_MODE_RST;
		end else if (cfg_valid) begin
			unique case (reg_idx_t'(cfg_index))
				REG_TILE_WIDTH: tile_width_q <= cfg_data;
				REG_COLOR_MODE: color_mode_q <= cfg_data[0];
			endcase
		end
	end

	// a held emitting item blocks only if the output register cannot take it
	assign s_tready = !s1_valid || !s1_emit || out_ready;
	assign in_acc   = s_tvalid && s_tready;
	assign blk_end  = pos.active && pos.odd_col && pos.odd_row;

	always_comb begin
		for (int c = 0; c < NCH; c++) begin
			if (c < CHANNELS && (c == 0 || color_mode_q)) begin
				px[c] = s_tdata[c*PIX_W +: PIX_W];
			end else begin
				px[c] = '0;
			end
			pair[c] = SUM_W'(held_q[c]) + SUM_W'(px[c]);
		end
	end

	bxds_pos #(
		.MAX_TILE_WIDTH(MAX_TILE_WIDTH),
		.CW(CW),
		.WW(WW),
		.LW(LW)
	) u_pos (
		.clk(clk),
		.arst_n(arst_n),
		.advance(in_acc),
		.tile_width(tile_width_q),
		.pos(pos),
		.line_idx(line_idx)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q <= '0;
		end else if (in_acc && pos.active && !pos.odd_col) begin
			held_q <= px;
		end
	end

	// even rows store pair sums, odd rows read them back
	bxds_line #(
		.DEPTH(DEPTH),
		.AW(LW)
	) u_line (
		.clk(clk),
		.wr_en(in_acc && pos.active && pos.odd_col && !pos.odd_row),
		.wr_addr(line_idx),
		.wr_data(pair),
		.rd_en(in_acc),
		.rd_addr(line_idx),
		.rd_data(line_rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid <= 1'b0;
		end else if (s_tready) begin
			s1_valid <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			s1_emit <= blk_end;
			s1_done <= pos.done;
			s1_col  <= pos.col_h;
			s1_row  <= pos.row_h;
			s1_pair <= pair;
		end
	end

	bxds_out u_out (
		.clk(clk),
		.arst_n(arst_n),
		.load(s1_valid && s1_emit),
		.line_sum(line_rd),
		.pair_sum(s1_pair),
		.col_h(s1_col),
		.row_h(s1_row),
		.done(s1_done),
		.can_load(out_ready),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tlast(m_tlast)
	);

	`BXDS_ASSERT(a_last_on_diag, m_tvalid && m_tlast, m_tdata[31:24] == m_tdata[39:32], "off diagonal")
	`BXDS_ASSERT(a_stall_blocks, s1_valid && s1_emit && !out_ready, !s_tready, "stall leak")
	`BXDS_ASSERT_NEXT(a_emit_follows, in_acc && blk_end, s1_valid && s1_emit, "block lost")

endmodule

`default_nettype wire

@@ dv/tb_box_downscale_2x2.sv @@
module tb_box_downscale_2x2;
	timeunit 1ns;
	timeprecision 1ps;

	import bxds_pkg::*;

	localparam int unsigned SETTLE   = 8;       // cycles past the last result before a write
	localparam int unsigned MAX_GAP  = 40;
	localparam int unsigned LIMIT    = 500000;
	localparam int unsigned PHASE_PX = 50;
	localparam int          MAX_W    = 512;

	typedef struct packed {
		logic [7:0] c0;
		logic [7:0] c1;
		logic [7:0] c2;
		logic [7:0] col;
		logic [7:0] row;
		logic       done;
	} blk_avg_t;

	typedef struct {
		bit           is_wr;
		reg_idx_t     idx;
		logic [9:0]   val;
		logic [7:0]   c0, c1, c2;
		bit           typed;
		blk_avg_t     res;
	} dir_row_t;

	logic                  clk;
	logic                  arst_n    = 1'b0;
	logic                  s_tvalid  = 1'b0;
	logic                  s_tready;
	logic [23:0]           s_tdata   = '0;  // pix_c0, pix_c1, pix_c2
	logic                  m_tvalid;
	logic                  m_tready  = 1'b0;
	logic [39:0]           m_tdata;         // avg_c0, avg_c1, avg_c2, out_col, out_row
	logic                  m_tlast;         // tile_done
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	reg_idx_t              cfg_index = REG_TILE_WIDTH;
	logic [CFG_W-1:0]      cfg_data  = '0;

	// predictor state
	logic [CFG_W-1:0]      tw_reg   = TILE_WIDTH_RST;
	logic                  mode_reg = COLOR_MODE_RST;
	int unsigned           pos_col  = 0;
	int unsigned           pos_row  = 0;
	logic [23:0]           held_px  = '0;
	logic [26:0]           pair_line [MAX_W/2];

	blk_avg_t              pending_avg [$];
	dir_row_t              dir_tab [$];

	int unsigned           send_pct = 0;
	int unsigned           recv_pct = 0;
	int unsigned           cycles   = 0;
	int unsigned           n_pix    = 0;
	int unsigned           n_blk    = 0;
	int unsigned           n_wr     = 0;
	int unsigned           n_err    = 0;

	box_downscale_2x2 u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= LIMIT) begin
			$display("timeout after %0d cycles, %0d results still pending", cycles,
				pending_avg.size());
			$display("tb_box_downscale_2x2 NOT OK");
			$finish;
		end
	end

	function automatic int unsigned eff_width();
		int unsigned w;
		w = 32'(tw_reg);
		if (w < 2) w = 2;
		if (w > MAX_W) w = MAX_W;
		return w;
	endfunction

	// one pixel in; returns 1 when it closes a 2x2 block
	function automatic bit downscale_pixel(input logic [23:0] din, output blk_avg_t r);
		int unsigned w, h, idx;
		int          c;
		logic [23:0] px, avg;
		logic [26:0] pair;
		logic [9:0]  s10;
		bit          hit;
		w = eff_width();
		h = w / 2;
		hit = 1'b0;
		r = '0;
		avg = '0;
		px = mode_reg ? din : {16'h0000, din[7:0]};
		if (pos_col / 2 < h && pos_row / 2 < h) begin
			if (pos_col % 2 == 0) begin
				held_px = px;
			end else begin
				for (c = 0; c < 3; c++)
					pair[9*c +: 9] = 9'(held_px[8*c +: 8]) + 9'(px[8*c +: 8]);
				idx = (pos_col / 2) % (MAX_W / 2);
				if (pos_row % 2 == 0) begin
					pair_line[idx] = pair;
				end else begin
					for (c = 0; c < 3; c++) begin
						s10 = 10'(pair_line[idx][9*c +: 9]) + 10'(pair[9*c +: 9]);
						avg[8*c +: 8] = s10[9:2];
					end
					r.c0 = avg[7:0];
					r.c1 = avg[15:8];
					r.c2 = avg[23:16];
					r.col = 8'(pos_col / 2);
					r.row = 8'(pos_row / 2);
					r.done = (pos_col / 2 == h - 1) && (pos_row / 2 == h - 1);
					hit = 1'b1;
				end
			end
		end
		// pixels past the width are dropped and wrap the position
		if (pos_col + 1 >= w) begin
			pos_col = 0;
			pos_row = (pos_row + 1 >= w) ? 0 : pos_row + 1;
		end else begin
			pos_col = pos_col + 1;
		end
		return hit;
	endfunction

	function automatic logic [7:0] rand_chan();
		int unsigned k;
		k = $urandom_range(99);
		if (k < 15) return 8'h00;
		if (k < 30) return 8'hFF;
		return 8'($urandom_range(255));
	endfunction

	task automatic flag_mismatch(input string why, input blk_avg_t e, input blk_avg_t a);
		n_err++;
		if (n_err <= 10)
			$display("%0t %s: exp %0d/%0d/%0d @%0d,%0d l%0d got %0d/%0d/%0d @%0d,%0d l%0d",
				$realtime, why, e.c0, e.c1, e.c2, e.col, e.row, e.done,
				a.c0, a.c1, a.c2, a.col, a.row, a.done);
	endtask

	always @(posedge clk) begin
		blk_avg_t act, e;
		if (arst_n && m_tvalid && m_tready) begin
			act.c0 = m_tdata[7:0];
			act.c1 = m_tdata[15:8];
			act.c2 = m_tdata[23:16];
			act.col = m_tdata[31:24];
			act.row = m_tdata[39:32];
			act.done = m_tlast;
			if (pending_avg.size() == 0) begin
				flag_mismatch("result with nothing pending", '0, act);
			end else begin
				e = pending_avg.pop_front();
				if (act.c0 !== e.c0 || act.c1 !== e.c1 || act.c2 !== e.c2 ||
						act.col !== e.col || act.row !== e.row || act.done !== e.done)
					flag_mismatch("result mismatch", e, act);
				n_blk++;
			end
		end
		m_tready <= ($urandom_range(99) >= recv_pct);
	end

	// drop valid, let every pending result arrive, then let the pipe settle
	task automatic wait_idle();
		s_tvalid <= 1'b0;
		while (pending_avg.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_reg(input reg_idx_t idx, input logic [9:0] val);
		wait_idle();
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
		if (idx == REG_TILE_WIDTH) tw_reg = val;
		else mode_reg = val[0];
		cfg_valid <= 1'b0;
		n_wr++;
	endtask

	task automatic send_pixel(input logic [7:0] c0, c1, c2, input bit typed,
			input blk_avg_t tres);
		blk_avg_t    p;
		bit          got;
		int unsigned gap;
		s_tvalid <= 1'b1;
		s_tdata  <= {c2, c1, c0};
		do @(posedge clk); while (!s_tready);
		got = downscale_pixel({c2, c1, c0}, p);
		if (typed) pending_avg.push_back(tres);
		else if (got) pending_avg.push_back(p);
		n_pix++;
		gap = 0;
		while (gap < MAX_GAP && $urandom_range(99) < send_pct) gap++;
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic send_rand_pixel();
		send_pixel(rand_chan(), rand_chan(), rand_chan(), 1'b0, '0);
		// hold off now and then until the output side has caught up
		if ($urandom_range(199) == 0) wait_idle();
	endtask

	task automatic add_wr(input reg_idx_t idx, input logic [9:0] val);
		dir_row_t r;
		r = '{is_wr: 1'b1, idx: idx, val: val, c0: '0, c1: '0, c2: '0, typed: 1'b0, res: '0};
		dir_tab.push_back(r);
	endtask

	task automatic add_pix(input logic [7:0] c0, c1, c2, input bit typed, input blk_avg_t res);
		dir_row_t r;
		r = '{is_wr: 1'b0, idx: REG_TILE_WIDTH, val: '0, c0: c0, c1: c1, c2: c2,
			typed: typed, res: res};
		dir_tab.push_back(r);
	endtask

	// one whole tile at a fresh setting; sometimes the width is cut mid-tile
	task automatic run_tile();
		int unsigned k, w, total, cut, i;
		k = $urandom_range(99);
		if (k < 5) w = $urandom_range(1);
		else if (k < 92) w = $urandom_range(2, 12);
		else w = $urandom_range(13, 20);
		write_reg(REG_TILE_WIDTH, 10'(w));
		if ($urandom_range(2) == 0) write_reg(REG_COLOR_MODE, 10'($urandom_range(1)));
		w = eff_width();
		total = w * w;
		cut = ($urandom_range(9) == 0) ? $urandom_range(1, total - 1) : total;
		for (i = 0; i < cut; i++) send_rand_pixel();
		if (cut < total) begin
			// lowering only: every line entry read later was written in this tile
			write_reg(REG_TILE_WIDTH, 10'($urandom_range(0, w - 1)));
			if ($urandom_range(1) == 0) write_reg(REG_COLOR_MODE, 10'($urandom_range(1)));
			while (pos_col != 0 || pos_row != 0) send_rand_pixel();
		end
	endtask

	initial begin
		int unsigned start, ph, i;
		dir_row_t    r;

		// w=2 tiles: one block each, always the last of the tile
		add_wr(REG_TILE_WIDTH, 10'd2);
		add_wr(REG_COLOR_MODE, 10'd1);
		repeat (3) add_pix(8'd255, 8'd255, 8'd255, 1'b0, '0);
		add_pix(8'd255, 8'd255, 8'd255, 1'b1, '{8'd255, 8'd255, 8'd255, 8'd0, 8'd0, 1'b1});
		repeat (3) add_pix(8'd1, 8'd2, 8'd3, 1'b0, '0);
		add_pix(8'd0, 8'd2, 8'd3, 1'b1, '{8'd0, 8'd2, 8'd3, 8'd0, 8'd0, 1'b1});
		// grey: channels one and two read as zero
		add_wr(REG_COLOR_MODE, 10'd0);
		repeat (3) add_pix(8'd200, 8'd255, 8'd255, 1'b0, '0);
		add_pix(8'd200, 8'd255, 8'd255, 1'b1, '{8'd200, 8'd0, 8'd0, 8'd0, 8'd0, 1'b1});
		// width below range clamps to 2
		add_wr(REG_TILE_WIDTH, 10'd0);
		add_pix(8'd0, 8'd0, 8'd0, 1'b0, '0);
		add_pix(8'd255, 8'd255, 8'd255, 1'b0, '0);
		add_pix(8'd128, 8'd1, 8'd2, 1'b0, '0);
		add_pix(8'd127, 8'd3, 8'd4, 1'b0, '0);
		// odd width: last column and last row dropped
		add_wr(REG_TILE_WIDTH, 10'd3);
		add_wr(REG_COLOR_MODE, 10'd1);
		add_pix(8'd10, 8'd20, 8'd30, 1'b0, '0);
		add_pix(8'd11, 8'd21, 8'd31, 1'b0, '0);
		add_pix(8'd255, 8'd255, 8'd255, 1'b0, '0);
		add_pix(8'd12, 8'd22, 8'd32, 1'b0, '0);
		add_pix(8'd13, 8'd23, 8'd33, 1'b0, '0);
		add_pix(8'd255, 8'd0, 8'd255, 1'b0, '0);
		add_pix(8'd0, 8'd255, 8'd0, 1'b0, '0);
		add_pix(8'd255, 8'd255, 8'd255, 1'b0, '0);
		add_pix(8'd0, 8'd0, 8'd0, 1'b0, '0);

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_pct = 32;
		recv_pct = 84;
		foreach (dir_tab[j]) begin
			r = dir_tab[j];
			if (r.is_wr) write_reg(r.idx, r.val);
			else send_pixel(r.c0, r.c1, r.c2, r.typed, r.res);
		end

		for (ph = 0; ph < 3; ph++) begin
			send_pct = (ph == 0) ? 32 : (ph == 1) ? 84 : 0;
			recv_pct = (ph == 0) ? 84 : (ph == 1) ? 32 : 0;
			if (ph == 2) begin
				// full width: two rows reach the top column, then cut to 3 past the end
				write_reg(REG_TILE_WIDTH, 10'd512);
				write_reg(REG_TILE_WIDTH, 10'd1023);
				write_reg(REG_COLOR_MODE, 10'd1);
				for (i = 0; i < 2 * MAX_W + 20; i++) send_rand_pixel();
				write_reg(REG_TILE_WIDTH, 10'd3);
				while (pos_col != 0 || pos_row != 0) send_rand_pixel();
			end
			start = n_pix;
			while (n_pix - start < PHASE_PX) run_tile();
		end

		wait_idle();
		repeat (20) @(posedge clk);
		$display("ran %0d pixels, %0d blocks, %0d register writes in %0d cycles",
			n_pix, n_blk, n_wr, cycles);
		$display("widths 0..1023 with clamping, odd widths, grey and RGB, mid-tile cuts");
		if (n_err == 0) begin
			$display("tb_box_downscale_2x2 OK");
		end else begin
			$display("%0d mismatches", n_err);
			$display("tb_box_downscale_2x2 NOT OK");
		end
		$finish;
	end

endmodule
